>>> sv/lpht_pkg.sv
package lpht_pkg;

  localparam int ACT_W      = 2;
  localparam int KEY_W      = 31;
  localparam int VAL_W      = 32;
  localparam int STAT_W     = 2;
  localparam int SLOT_W     = 4;
  localparam int RCNT_W     = 5;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 80;
  localparam int RCNT_MAX   = 31;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_REMOVE = 2'd2
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_INIT_CLR,
    S_IDLE,
    S_HASH,
    S_PRB_RD,
    S_PRB_CHK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_RM_CLR,
    S_RI_NEXT,
    S_RI_LOAD,
    S_RESULT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic hash_start;
    logic ri_load;
    logic probe_setup;
    logic addr_inc;
    logic cnt_inc;
    logic addr_zero;
    logic tbl_clr;
    logic ins_wr;
    logic hit_cap;
    logic st_ok;
    logic st_full;
    logic scan_chk;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic             mod_done;
    logic             probe_hit;
    logic             probe_last;
    logic             addr_last;
    logic             scan_any;
    logic             keep_done;
    logic             out_free;
    logic [ACT_W-1:0] in_act;
    logic [ACT_W-1:0] act;
  } sts_t;

endpackage

>>> sv/lpht_ram.sv
module lpht_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/lpht_mod.sv
// Key modulo table size: multiply by a fixed reciprocal, subtract the matching
// multiple of the table size, then correct the remainder once.
module lpht_mod import lpht_pkg::*; #(
  parameter int TABLE_SIZE = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [KEY_W-1:0]              key,
  output logic                          done,
  output logic [$clog2(TABLE_SIZE)-1:0] home
);

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int MW = KEY_W + 1;
  localparam int PW = KEY_W + MW;
  localparam int SH = KEY_W + IW;
  localparam int QW = PW - SH;
  // The reciprocal undershoots by less than one, so the quotient estimate is at
  // most one too small and a single compare and subtract finishes the remainder.
  localparam logic [63:0]   RECIP_FULL = (64'd1 << SH) / 64'(TABLE_SIZE);
  localparam logic [MW-1:0] RECIP      = MW'(RECIP_FULL);
  localparam logic [IW:0]   DIVISOR    = (IW+1)'(TABLE_SIZE);

  logic [2:0]       vld_r;
  logic             done_r;
  logic [KEY_W-1:0] key_r;
  logic [PW-1:0]    prod_r;
  logic [IW:0]      diff_r;
  logic [IW-1:0]    home_r;
  logic [QW-1:0]    quot;
  logic [MW-1:0]    diff_full;

  assign quot      = prod_r[PW-1:SH];
  assign diff_full = MW'(key_r) - MW'(quot) * MW'(TABLE_SIZE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      done_r <= 1'b0;
    end else begin
      vld_r  <= {vld_r[1:0], start};
      done_r <= vld_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      key_r <= key;
    end
    if (vld_r[0]) begin
      prod_r <= PW'(key_r) * PW'(RECIP);
    end
    if (vld_r[1]) begin
      diff_r <= diff_full[IW:0];
    end
    if (vld_r[2]) begin
      home_r <= (diff_r >= DIVISOR) ? IW'(diff_r - DIVISOR) : diff_r[IW-1:0];
    end
  end

  assign done = done_r;
  assign home = home_r;

endmodule

>>> sv/lpht_datapath.sv
module lpht_datapath import lpht_pkg::*; #(
  parameter int TABLE_SIZE = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int CW = $clog2(TABLE_SIZE + 1);
  localparam int PW = KEY_W + VAL_W;
  localparam int TW = 1 + PW;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SIZE - 1);

  logic [ACT_W-1:0] in_act;
  logic [KEY_W-1:0] in_key;
  logic [VAL_W-1:0] in_val;

  logic [ACT_W-1:0] act_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  status_t          st_r;
  logic [IW-1:0]    addr_r, cnt_r;
  logic [CW-1:0]    keep_cnt_r, keep_idx_r, cleared_r;
  logic [KEY_W-1:0] rkey_r;
  logic [IW-1:0]    hit_slot_r;
  logic [VAL_W-1:0] hit_val_r;
  logic             out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [TW-1:0]    tbl_rdata, tbl_wdata;
  logic             tbl_we;
  logic             rd_valid;
  logic [KEY_W-1:0] rd_key;
  logic [VAL_W-1:0] rd_val;
  logic             val_match;

  logic [PW-1:0]    kp_rdata;
  logic [KEY_W-1:0] kp_key;
  logic [VAL_W-1:0] kp_val;
  logic             kp_we;

  logic [KEY_W-1:0] mod_key;
  logic             mod_done;
  logic [IW-1:0]    home;

  logic             is_ok;
  logic [SLOT_W-1:0] o_slot;
  logic [VAL_W-1:0]  o_found;
  logic [KEY_W-1:0]  o_rkey;
  logic [RCNT_W-1:0] o_rcount;

  assign in_act = in_tdata[ACT_W-1:0];
  assign in_key = in_tdata[ACT_W+KEY_W-1:ACT_W];
  assign in_val = in_tdata[ACT_W+PW-1:ACT_W+KEY_W];

  assign rd_valid  = tbl_rdata[TW-1];
  assign rd_key    = tbl_rdata[PW-1:VAL_W];
  assign rd_val    = tbl_rdata[VAL_W-1:0];
  assign val_match = rd_valid && (rd_val == val_r);

  assign kp_key = kp_rdata[PW-1:VAL_W];
  assign kp_val = kp_rdata[VAL_W-1:0];

  assign tbl_we    = cmd.tbl_clr | cmd.ins_wr;
  assign tbl_wdata = cmd.ins_wr ? {1'b1, key_r, val_r} : '0;
  assign kp_we     = cmd.scan_chk && rd_valid && !val_match;
  assign mod_key   = cmd.ri_load ? kp_key : in_key;

  lpht_ram #(.WIDTH(TW), .DEPTH(TABLE_SIZE)) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (addr_r),
    .wdata (tbl_wdata),
    .raddr (addr_r),
    .rdata (tbl_rdata)
  );

  // Survivors of a remove, in ascending slot order.
  lpht_ram #(.WIDTH(PW), .DEPTH(TABLE_SIZE)) u_keep (
    .clk   (clk),
    .we    (kp_we),
    .waddr (keep_cnt_r[IW-1:0]),
    .wdata ({rd_key, rd_val}),
    .raddr (keep_idx_r[IW-1:0]),
    .rdata (kp_rdata)
  );

  lpht_mod #(.TABLE_SIZE(TABLE_SIZE)) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.hash_start),
    .key   (mod_key),
    .done  (mod_done),
    .home  (home)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= '0;
      st_r        <= ST_NOT_FOUND;
      addr_r      <= '0;
      cnt_r       <= '0;
      keep_cnt_r  <= '0;
      keep_idx_r  <= '0;
      cleared_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        act_r      <= in_act;
        st_r       <= ST_NOT_FOUND;
        addr_r     <= '0;
        keep_cnt_r <= '0;
        keep_idx_r <= '0;
        cleared_r  <= '0;
      end
      if (cmd.ri_load) begin
        keep_idx_r <= keep_idx_r + CW'(1);
      end
      if (cmd.probe_setup) begin
        addr_r <= home;
        cnt_r  <= '0;
      end
      if (cmd.addr_inc) begin
        addr_r <= (addr_r == LAST_IDX) ? '0 : addr_r + IW'(1);
      end
      if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + IW'(1);
      end
      if (cmd.addr_zero) begin
        addr_r <= '0;
      end
      if (cmd.st_ok) begin
        st_r <= ST_OK;
      end
      if (cmd.st_full) begin
        st_r <= ST_FULL;
      end
      if (cmd.scan_chk && val_match) begin
        cleared_r <= cleared_r + CW'(1);
      end
      if (kp_we) begin
        keep_cnt_r <= keep_cnt_r + CW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_r <= in_key;
      val_r <= in_val;
    end
    if (cmd.ri_load) begin
      key_r <= kp_key;
      val_r <= kp_val;
    end
    if (cmd.ins_wr || cmd.hit_cap) begin
      hit_slot_r <= addr_r;
      hit_val_r  <= rd_val;
    end
    if (cmd.scan_chk && val_match && (cleared_r == '0)) begin
      rkey_r <= rd_key;
    end
    if (cmd.out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_comb begin
    is_ok    = (st_r == ST_OK);
    o_slot   = (is_ok && (act_r == ACT_INSERT || act_r == ACT_LOOKUP)) ?
               SLOT_W'(hit_slot_r) : '0;
    o_found  = (is_ok && act_r == ACT_LOOKUP) ? hit_val_r : '0;
    o_rkey   = (is_ok && act_r == ACT_REMOVE) ? rkey_r : '0;
    o_rcount = '0;
    if (is_ok && act_r == ACT_REMOVE) begin
      o_rcount = (32'(cleared_r) > 32'(RCNT_MAX)) ? RCNT_W'(RCNT_MAX) : RCNT_W'(cleared_r);
    end
    out_data_nxt = {{(OUT_DATA_W-STAT_W-SLOT_W-VAL_W-KEY_W-RCNT_W){1'b0}},
                    o_rcount, o_rkey, o_found, o_slot, st_r};
  end

  always_comb begin
    sts.mod_done   = mod_done;
    sts.probe_hit  = (act_r == ACT_LOOKUP) ? (rd_valid && rd_key == key_r) : !rd_valid;
    sts.probe_last = (cnt_r == LAST_IDX);
    sts.addr_last  = (addr_r == LAST_IDX);
    sts.scan_any   = (cleared_r != '0) || val_match;
    sts.keep_done  = (keep_idx_r == keep_cnt_r);
    sts.out_free   = !out_valid_r || out_tready;
    sts.in_act     = in_act;
    sts.act        = act_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> sv/lpht_ctrl.sv
module lpht_ctrl import lpht_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_INIT_CLR: begin
        cmd.tbl_clr = 1'b1;
        if (sts.addr_last) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.addr_inc = 1'b1;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          case (sts.in_act)
            ACT_INSERT, ACT_LOOKUP: begin
              cmd.hash_start = 1'b1;
              state_nxt      = S_HASH;
            end
            ACT_REMOVE: state_nxt = S_SCAN_RD;
            default:    state_nxt = S_RESULT;
          endcase
        end
      end
      S_HASH: begin
        if (sts.mod_done) begin
          cmd.probe_setup = 1'b1;
          state_nxt       = S_PRB_RD;
        end
      end
      S_PRB_RD: state_nxt = S_PRB_CHK;
      S_PRB_CHK: begin
        if (sts.probe_hit) begin
          case (sts.act)
            ACT_LOOKUP: begin
              cmd.hit_cap = 1'b1;
              cmd.st_ok   = 1'b1;
              state_nxt   = S_RESULT;
            end
            ACT_INSERT: begin
              cmd.ins_wr = 1'b1;
              cmd.st_ok  = 1'b1;
              state_nxt  = S_RESULT;
            end
            default: begin
              cmd.ins_wr = 1'b1;
              state_nxt  = S_RI_NEXT;
            end
          endcase
        end else if (sts.probe_last) begin
          case (sts.act)
            ACT_INSERT: begin
              cmd.st_full = 1'b1;
              state_nxt   = S_RESULT;
            end
            ACT_LOOKUP: state_nxt = S_RESULT;
            default:    state_nxt = S_RI_NEXT;
          endcase
        end else begin
          cmd.addr_inc = 1'b1;
          cmd.cnt_inc  = 1'b1;
          state_nxt    = S_PRB_RD;
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN_CHK;
      S_SCAN_CHK: begin
        cmd.scan_chk = 1'b1;
        if (sts.addr_last) begin
          if (sts.scan_any) begin
            cmd.st_ok     = 1'b1;
            cmd.addr_zero = 1'b1;
            state_nxt     = S_RM_CLR;
          end else begin
            state_nxt = S_RESULT;
          end
        end else begin
          cmd.addr_inc = 1'b1;
          state_nxt    = S_SCAN_RD;
        end
      end
      S_RM_CLR: begin
        cmd.tbl_clr = 1'b1;
        if (sts.addr_last) begin
          state_nxt = S_RI_NEXT;
        end else begin
          cmd.addr_inc = 1'b1;
        end
      end
      S_RI_NEXT: begin
        state_nxt = sts.keep_done ? S_RESULT : S_RI_LOAD;
      end
      S_RI_LOAD: begin
        cmd.ri_load    = 1'b1;
        cmd.hash_start = 1'b1;
        state_nxt      = S_HASH;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> sv/linear_probe_hash_table.sv
// Open-addressing hash table with linear probing, TABLE_SIZE key/value slots.
// Input transactions on in_* carry an action (insert, lookup, remove by value),
// a key and a value; every input transaction yields exactly one result
// transaction on out_* with a status, a slot index, a found value, the key of
// the lowest removed slot and the number of slots removed.
// The home slot is key mod TABLE_SIZE, found by multiplying with a fixed
// reciprocal and correcting the remainder once. Each probe reads the
// registered table; insert and lookup present their result after at most
// TABLE_SIZE probes, and in_tready is high again in the same cycle as the result.
// Remove scans the table and, if anything matched, clears it and reinserts
// every survivor by probing for a free slot; the result follows once the
// last survivor is placed. One item is worked on at a time.
// After reset the table is swept clear, one slot a cycle, and in_tready
// stays low until that sweep is done.
// The result sits in an output register; a stalled receiver only holds the
// block once the next result is ready and that register is still full.
module linear_probe_hash_table import lpht_pkg::*; #(
  parameter int TABLE_SIZE = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // From bit 0: action[1:0], key[32:2], value[64:33], zero padding.
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // From bit 0: status[1:0], slot_index[5:2], found_value[37:6],
  // removed_key[68:38], removed_count[73:69], zero padding.
  output logic [OUT_DATA_W-1:0] out_tdata
);

  cmd_t cmd;
  sts_t sts;

  // The controller sequences hashing, probing, the removal scan and the rebuild.
  lpht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the slot memory, the survivor buffer, the hashing unit and
  // the result register.
  lpht_datapath #(.TABLE_SIZE(TABLE_SIZE)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
